// ===== hdl/bvg_pkg.sv =====
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared widths, constants and types of the battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

  // Field and state widths
  localparam int RawW = 12;
  localparam int SumW = 16;
  localparam int CntW = 5;
  localparam int PosW = 4;
  localparam int OhmW = 20;
  localparam int MvW  = 16;
  localparam int PctW = 7;

  // Shared divider: dividend, divisor and step counter widths
  localparam int DivW  = 32;
  localparam int DenW  = OhmW + 1;
  localparam int IterW = $clog2(DivW);

  // Conversion constants
  localparam int FullScaleMv = 1100;
  localparam int RoundAdd    = 2047;
  localparam int RawMax      = 4095;
  localparam int EmptyMv     = 3300;
  localparam int FullMv      = 4200;
  localparam int SpanMv      = 900;
  localparam int MvMax       = 65535;
  localparam int PctFull     = 100;

  // (mv - 3300) * 100 / 900 is v / 9, taken as v * 911 >> 13;
  // exact for every v below 1170
  localparam int PctRecip = 911;
  localparam int PctShift = 13;

  // Defaults
  localparam int SamplesDefault = 16;
  localparam int OhmReset       = 100000;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIV_TOP    = 1'b0,
    CFG_DIV_BOTTOM = 1'b1
  } cfg_idx_t;

  // One finished burst handed from front to back
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] count;
  } job_t;

endpackage

// ===== hdl/bvg_front.sv =====
// ----------------------------------------------------------------------------
// bvg_front
// Accepts readings, sums the good ones and hands each finished burst on.
// ----------------------------------------------------------------------------
module bvg_front
  import bvg_pkg::*;
#(
  parameter int SAMPLES = SamplesDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [RawW-1:0] in_raw_sample,
  input  logic            in_sample_ok,
  input  logic            q_full,
  output logic            push,
  output job_t            push_data
);

  localparam logic [PosW-1:0] LastPos = PosW'(SAMPLES - 1);

  logic [SumW-1:0] sum_r, sum_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            accept;
  logic            last;

  // Hold readings while the queue has no room for a burst
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign last     = (pos_r == LastPos);

  // Add the reading when it is good
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (in_sample_ok) begin
      sum_nxt = sum_r + SumW'(in_raw_sample);
      cnt_nxt = cnt_r + CntW'(1);
    end
    pos_nxt = pos_r + PosW'(1);
  end

  // Hand the burst totals to the queue on its last reading
  assign push            = accept && last;
  assign push_data.sum   = sum_nxt;
  assign push_data.count = cnt_nxt;

  // Advance or clear the burst accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
    end else if (accept) begin
      if (last) begin
        sum_r <= '0;
        cnt_r <= '0;
        pos_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  // Position never runs past the end of the burst
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LastPos)
    else $error("burst position beyond last reading");

  // Good count never exceeds readings taken so far
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(pos_r))
    else $error("good count larger than burst position");

  // A burst is handed on only while the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("burst pushed into full queue");

endmodule

// ===== hdl/bvg_fifo.sv =====
// ----------------------------------------------------------------------------
// bvg_fifo
// Two-entry queue of finished bursts between front and back.
// ----------------------------------------------------------------------------
module bvg_fifo
  import bvg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_data
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW:0]   cnt_r;

  assign full      = (cnt_r == (PtrW + 1)'(Depth));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PtrW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PtrW + 1)'(1);
      end
    end
  end

  // Pop only from a filled queue
  a_pop_filled: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  // Fill level tracks the pointer difference
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with level");

endmodule

// ===== hdl/bvg_div.sv =====
// ----------------------------------------------------------------------------
// bvg_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module bvg_div
  import bvg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [DenW-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic [DivW-1:0] quotient
);

  logic [DivW-1:0]  quo_r;
  logic [DenW:0]    rem_r;
  logic [DenW-1:0]  den_r;
  logic [IterW-1:0] iter_r;
  logic             busy_r;
  logic             done_r;
  logic [DenW:0]    rem_sh;
  logic             fits;
  logic             last_step;

  // Shift in the next dividend bit and try the subtraction
  assign rem_sh    = {rem_r[DenW-1:0], quo_r[DivW-1]};
  assign fits      = (rem_sh >= {1'b0, den_r});
  assign last_step = (iter_r == IterW'(DivW - 1));

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        iter_r <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        rem_r  <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
        quo_r  <= {quo_r[DivW-2:0], fits};
        iter_r <= iter_r + IterW'(1);
        done_r <= last_step;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Completion comes only out of a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

// ===== hdl/bvg_back.sv =====
// ----------------------------------------------------------------------------
// bvg_back
// Sequencer that turns a burst total into millivolts and charge percent.
// ----------------------------------------------------------------------------
module bvg_back
  import bvg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  job_t            q_data,
  output logic            pop,
  input  logic [OhmW-1:0] div_top,
  input  logic [OhmW-1:0] div_bottom,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [MvW-1:0]  out_voltage_mv,
  output logic [PctW-1:0] out_charge_percent,
  output logic            out_failed
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_MUL1,
    S_DMV,
    S_MUL2,
    S_MV,
    S_PCT,
    S_OUT
  } state_t;

  state_t          state_r;
  logic            start_r;
  logic [DivW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [RawW-1:0] avg_r;
  logic [10:0]     dmv_r;
  logic [DenW-1:0] ohm_sum_r;
  logic [OhmW-1:0] bot_r;
  logic [MvW-1:0]  mv_r;
  logic [PctW-1:0] pct_r;
  logic            fail_r;
  logic            out_valid_r;
  logic [MvW-1:0]  out_mv_r;
  logic [PctW-1:0] out_pct_r;
  logic            out_failed_r;

  logic            div_busy;
  logic            div_done;
  logic [DivW-1:0] div_quo;
  logic            out_free;
  logic [MvW-1:0]  mv_over;
  logic [DivW-1:0] dmv_sum;
  logic [DivW-1:0] pct_prod;

  bvg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (num_r),
    .divisor  (den_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign pop      = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign mv_over  = mv_r - MvW'(EmptyMv);

  // Divide by 4095 = 2^12 - 1: fold the high part back in, then shift
  assign dmv_sum  = num_r + (num_r >> RawW) + DivW'(1);

  // Charge percent by reciprocal multiply
  assign pct_prod = DivW'(mv_over) * DivW'(PctRecip);

  assign out_valid          = out_valid_r;
  assign out_voltage_mv     = out_mv_r;
  assign out_charge_percent = out_pct_r;
  assign out_failed         = out_failed_r;

  // Step through the conversion; each multiply lands in a register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.count == '0) begin
              mv_r    <= '0;
              pct_r   <= '0;
              fail_r  <= 1'b1;
              state_r <= S_OUT;
            end else begin
              fail_r  <= 1'b0;
              num_r   <= DivW'(q_data.sum);
              den_r   <= DenW'(q_data.count);
              start_r <= 1'b1;
              state_r <= S_AVG;
            end
          end
        end
        S_AVG: begin
          start_r <= 1'b0;
          if (div_done) begin
            avg_r   <= div_quo[RawW-1:0];
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          num_r   <= DivW'(avg_r) * DivW'(FullScaleMv) + DivW'(RoundAdd);
          state_r <= S_DMV;
        end
        S_DMV: begin
          dmv_r     <= dmv_sum[RawW +: 11];
          ohm_sum_r <= DenW'(div_top) + DenW'(div_bottom);
          bot_r     <= div_bottom;
          state_r   <= S_MUL2;
        end
        S_MUL2: begin
          if (bot_r == '0) begin
            mv_r    <= MvW'(MvMax);
            state_r <= S_PCT;
          end else begin
            num_r   <= DivW'(dmv_r) * DivW'(ohm_sum_r) + DivW'(bot_r >> 1);
            den_r   <= DenW'(bot_r);
            start_r <= 1'b1;
            state_r <= S_MV;
          end
        end
        S_MV: begin
          start_r <= 1'b0;
          if (div_done) begin
            mv_r    <= (div_quo > DivW'(MvMax)) ? MvW'(MvMax) : div_quo[MvW-1:0];
            state_r <= S_PCT;
          end
        end
        S_PCT: begin
          if (mv_r <= MvW'(EmptyMv)) begin
            pct_r <= '0;
          end else if (mv_r >= MvW'(FullMv)) begin
            pct_r <= PctW'(PctFull);
          end else begin
            pct_r <= pct_prod[PctShift +: PctW];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_mv_r     <= mv_r;
            out_pct_r    <= pct_r;
            out_failed_r <= fail_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A failed burst reports zero voltage and zero charge
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_failed_r) |-> (out_mv_r == '0 && out_pct_r == '0))
    else $error("failed result carries nonzero values");

  // Charge percent stays within full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= PctW'(PctFull)))
    else $error("charge percent above full");

  // The divider is idle whenever no burst is in flight
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !div_busy)
    else $error("divider running with no burst in flight");

endmodule

// ===== hdl/battery_voltage_gauge_top.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_gauge_top
// Averages bursts of converter readings into battery millivolts and charge.
// ----------------------------------------------------------------------------
// Readings are accepted one per cycle; each burst of SAMPLES readings yields
// one result. After the last reading the back end runs two divisions on one
// shared 32-step divider: the average, then the divider ratio, which a zero
// bottom resistor skips; an empty burst skips both. The full-scale scaling
// and the charge percent use shift-and-add and a reciprocal multiply. A
// result can be held by out_stall. A two-entry burst queue lets the next
// burst be collected while the previous one is converted; readings stall
// only when both entries are waiting. Divider resistor writes are sampled
// when a burst's conversion reaches the ratio step.
module battery_voltage_gauge_top
  import bvg_pkg::*;
#(
  parameter int SAMPLES = SamplesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RawW-1:0]    in_raw_sample,
  input  logic               in_sample_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MvW-1:0]     out_voltage_mv,
  output logic [PctW-1:0]    out_charge_percent,
  output logic               out_failed,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [OhmW-1:0]    cfg_wdata
);

  logic [OhmW-1:0] div_top_r;
  logic [OhmW-1:0] div_bottom_r;
  logic            q_full;
  logic            q_push;
  job_t            q_push_data;
  logic            q_pop;
  logic            q_valid;
  job_t            q_data;

  // Hold the divider resistor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_top_r    <= OhmW'(OhmReset);
      div_bottom_r <= OhmW'(OhmReset);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIV_TOP:    div_top_r    <= cfg_wdata;
        CFG_DIV_BOTTOM: div_bottom_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bvg_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .in_sample_ok  (in_sample_ok),
    .q_full        (q_full),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  bvg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  bvg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .pop                (q_pop),
    .div_top            (div_top_r),
    .div_bottom         (div_bottom_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_voltage_mv     (out_voltage_mv),
    .out_charge_percent (out_charge_percent),
    .out_failed         (out_failed)
  );

endmodule

// ===== tb/tb_battery_voltage_gauge_top.sv =====
// ----------------------------------------------------------------------------
// tb_battery_voltage_gauge_top
// Burst-level check of the battery voltage gauge against a local predictor.
// ----------------------------------------------------------------------------
// Readings are sent in whole bursts. Each burst's readout is predicted from a
// local copy of the running sum, the good count and the divider registers.
// The readouts are queued in order and compared field by field as they come
// out. A directed table covers the field extremes, the empty burst, a zero
// and an extreme divider. Random bursts follow, under several divider
// settings and three idling patterns on the request and readout sides.
// Divider registers are written only while the gauge is idle.
// ----------------------------------------------------------------------------
module tb_battery_voltage_gauge_top
  import bvg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Samples     = SamplesDefault;
  localparam int QuietCycles = 300;

  typedef struct packed {
    logic [MvW-1:0]  voltage_mv;
    logic [PctW-1:0] charge_percent;
    logic            failed;
  } readout_t;

  typedef struct packed {
    logic [OhmW-1:0] top;
    logic [OhmW-1:0] bottom;
    logic [RawW-1:0] raw_even;
    logic [RawW-1:0] raw_odd;
    logic [15:0]     ok_mask;
    logic            typed;
    readout_t        want;
  } dir_row_t;

  logic               clk;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [RawW-1:0]    in_raw_sample      = '0;
  logic               in_sample_ok       = 1'b0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic [MvW-1:0]     out_voltage_mv;
  logic [PctW-1:0]    out_charge_percent;
  logic               out_failed;
  logic               cfg_we             = 1'b0;
  logic [CfgIdxW-1:0] cfg_index          = '0;
  logic [OhmW-1:0]    cfg_wdata          = '0;

  // Local copy of the gauge state and of the divider registers
  logic [SumW-1:0] acc_sum    = '0;
  logic [CntW-1:0] acc_count  = '0;
  logic [OhmW-1:0] div_top    = OhmW'(OhmReset);
  logic [OhmW-1:0] div_bottom = OhmW'(OhmReset);

  readout_t        pending_readouts [$];
  logic [RawW-1:0] burst_raw [Samples];
  logic [15:0]     burst_ok;
  int unsigned     in_idle_pct  = 0;
  int unsigned     out_idle_pct = 0;
  int unsigned     error_count  = 0;
  dir_row_t        dir_rows [10];

  battery_voltage_gauge_top #(
    .SAMPLES(Samples)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_sample     (in_raw_sample),
    .in_sample_ok      (in_sample_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_voltage_mv    (out_voltage_mv),
    .out_charge_percent(out_charge_percent),
    .out_failed        (out_failed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Compute the readout of one finished burst
  function automatic readout_t predict_readout(input logic [SumW-1:0] sum,
                                               input logic [CntW-1:0] count,
                                               input logic [OhmW-1:0] top,
                                               input logic [OhmW-1:0] bottom);
    readout_t          r;
    longint unsigned   avg;
    longint unsigned   dmv;
    longint unsigned   mv;
    longint unsigned   pct;
    r = '0;
    if (count == '0) begin
      r.failed = 1'b1;
      return r;
    end
    avg = longint'(sum) / longint'(count);
    dmv = (avg * FullScaleMv + RoundAdd) / RawMax;
    if (bottom == '0) begin
      mv = MvMax;
    end else begin
      mv = (dmv * (longint'(top) + longint'(bottom)) + longint'(bottom) / 2) /
           longint'(bottom);
      if (mv > MvMax) mv = MvMax;
    end
    if (mv <= EmptyMv) pct = 0;
    else if (mv >= FullMv) pct = PctFull;
    else pct = (mv - EmptyMv) * PctFull / SpanMv;
    r.voltage_mv     = mv[MvW-1:0];
    r.charge_percent = pct[PctW-1:0];
    return r;
  endfunction

  // Write one divider register and track it locally
  task automatic write_reg(input cfg_idx_t idx, input logic [OhmW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_DIV_TOP) div_top = value;
    else div_bottom = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop the request, drain every readout, then let the back end settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  // Send burst_raw / burst_ok as one burst and predict its readout
  task automatic send_burst(output readout_t pred);
    for (int i = 0; i < Samples; i++) begin
      @(negedge clk);
      while ($urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_raw_sample <= burst_raw[i];
      in_sample_ok  <= burst_ok[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (burst_ok[i]) begin
        acc_sum   = acc_sum + burst_raw[i];
        acc_count = acc_count + 1'b1;
      end
    end
    pred      = predict_readout(acc_sum, acc_count, div_top, div_bottom);
    acc_sum   = '0;
    acc_count = '0;
  endtask

  // Fill and send one random burst: mostly clustered readings, some wide spread
  task automatic run_random_burst();
    int unsigned kind;
    int unsigned ok_pct;
    int          center;
    int          v;
    readout_t    pred;
    kind   = $urandom_range(9);
    ok_pct = (kind == 0) ? 0 : (kind == 1) ? $urandom_range(100) : 95;
    center = ($urandom_range(1)) ? $urandom_range(2700, 1800) : $urandom_range(4095);
    for (int i = 0; i < Samples; i++) begin
      if (kind >= 6) begin
        burst_raw[i] = RawW'($urandom);
      end else begin
        v = center + int'($urandom_range(127)) - 64;
        if (v < 0) v = 0;
        if (v > RawMax) v = RawMax;
        burst_raw[i] = RawW'(v);
      end
      burst_ok[i] = ($urandom_range(99) < ok_pct);
    end
    send_burst(pred);
    pending_readouts.push_back(pred);
  endtask

  // Drive the receiver's stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Compare each accepted readout with the oldest expectation
  always @(posedge clk) begin : readout_check
    readout_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) begin
        $display("%0t: unexpected readout mv=%0d pct=%0d failed=%0d", $time,
                 out_voltage_mv, out_charge_percent, out_failed);
        error_count++;
      end else begin
        want = pending_readouts.pop_front();
        if (out_voltage_mv !== want.voltage_mv) begin
          $display("%0t: voltage_mv expected %0d actual %0d", $time,
                   want.voltage_mv, out_voltage_mv);
          error_count++;
        end
        if (out_charge_percent !== want.charge_percent) begin
          $display("%0t: charge_percent expected %0d actual %0d", $time,
                   want.charge_percent, out_charge_percent);
          error_count++;
        end
        if (out_failed !== want.failed) begin
          $display("%0t: failed expected %0d actual %0d", $time,
                   want.failed, out_failed);
          error_count++;
        end
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    readout_t        pred;
    logic [OhmW-1:0] top;
    logic [OhmW-1:0] bottom;

    // top, bottom, even raw, odd raw, ok mask, typed, expected readout
    dir_rows[0] = '{20'd100000, 20'd100000, 12'h000, 12'h000, 16'hFFFF, 1'b1,
                    '{16'd0, 7'd0, 1'b0}};
    dir_rows[1] = '{20'd100000, 20'd100000, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1,
                    '{16'd2200, 7'd0, 1'b0}};
    dir_rows[2] = '{20'd100000, 20'd100000, 12'hFFF, 12'h000, 16'h0000, 1'b1,
                    '{16'd0, 7'd0, 1'b1}};
    dir_rows[3] = '{20'd100000, 20'd0, 12'd2000, 12'd2000, 16'hFFFF, 1'b1,
                    '{16'd65535, 7'd100, 1'b0}};
    dir_rows[4] = '{20'hFFFFF, 20'd1, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1,
                    '{16'd65535, 7'd100, 1'b0}};
    dir_rows[5] = '{20'd0, 20'hFFFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1,
                    '{16'd1100, 7'd0, 1'b0}};
    dir_rows[6] = '{20'd600000, 20'd100000, 12'h555, 12'hAAA, 16'hFFFF, 1'b0,
                    '0};
    dir_rows[7] = '{20'd600000, 20'd100000, 12'd3000, 12'd0, 16'h0100, 1'b0,
                    '0};
    // Empty burst wins over a zero bottom resistor
    dir_rows[8] = '{20'd0, 20'd0, 12'hFFF, 12'hFFF, 16'h0000, 1'b1,
                    '{16'd0, 7'd0, 1'b1}};
    dir_rows[9] = '{20'd500000, 20'd100000, 12'h123, 12'hEDC, 16'h8001, 1'b0,
                    '0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    in_idle_pct  = 12;
    out_idle_pct = 86;
    foreach (dir_rows[r]) begin
      wait_idle();
      write_reg(CFG_DIV_TOP, dir_rows[r].top);
      write_reg(CFG_DIV_BOTTOM, dir_rows[r].bottom);
      for (int i = 0; i < Samples; i++) begin
        burst_raw[i] = i[0] ? dir_rows[r].raw_odd : dir_rows[r].raw_even;
      end
      burst_ok = dir_rows[r].ok_mask;
      send_burst(pred);
      pending_readouts.push_back(dir_rows[r].typed ? dir_rows[r].want : pred);
    end

    // Random bursts: three idling patterns, four divider settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 12;
          out_idle_pct = 86;
        end
        1: begin
          in_idle_pct  = 86;
          out_idle_pct = 12;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          // Ratio near 7, puts mid-scale readings into the charge window
          0: begin
            top    = OhmW'($urandom_range(650000, 500000));
            bottom = OhmW'(100000);
          end
          1: begin
            top    = OhmW'($urandom);
            bottom = OhmW'($urandom);
          end
          2: begin
            case ($urandom_range(2))
              0: top = '0;
              1: top = '1;
              default: top = OhmW'($urandom);
            endcase
            bottom = $urandom_range(1) ? OhmW'(1) : '1;
          end
          default: begin
            top    = OhmW'($urandom);
            bottom = '0;
          end
        endcase
        wait_idle();
        write_reg(CFG_DIV_TOP, top);
        write_reg(CFG_DIV_BOTTOM, bottom);
        repeat (2) run_random_burst();
      end
    end

    // Drain and report
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
